### sv/nqbs_pkg.sv
// Shared constants for the N-queens backtracking solver.
// No dependencies; used by the solver core and its port checker.
`default_nettype none

package nqbs_pkg;

    // Largest board the solver is built for by default.
    localparam int MAX_SIZE_DEF = 16;

    // A request never produces more result items than this, which also caps
    // the usable board size regardless of MAX_SIZE.
    localparam int RESULT_CAP = 16;

    // Width of the row_index and queen_column result ports.
    localparam int COORD_W = 4;

endpackage

`default_nettype wire

### sv/n_queens_backtrack_solver_core.sv
// One column trial per cycle, except while a backtrack step reads the previous row's queen
// and then lifts it. Then one result item per row follows on consecutive cycles, the first
// once the state register has entered output and the strobe register has been set.
// Start is taken only while idle; a search holds busy until its final result item is issued.
// Sizes zero and above the limit give their single result item in the cycle after start.
// Reset (rst_n, asynchronous, active low) returns the solver to idle with no result pending.
//
// Solver core: depth-first N-queens search with the placed column of every row held in a
// small synchronous memory. Depends on nqbs_pkg for its default size and port widths.
`default_nettype none

module n_queens_backtrack_solver_core #(
    parameter int MAX_SIZE = nqbs_pkg::MAX_SIZE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [4:0]                    board_size,
    output logic                               strobe,
    output logic [nqbs_pkg::COORD_W-1:0]       row_index,
    output logic [nqbs_pkg::COORD_W-1:0]       queen_column,
    output logic                               queen_valid,
    output logic                               found,
    output logic                               last
);

    // The usable board limit is the smaller of MAX_SIZE and the result cap.
    localparam int LIMIT = (MAX_SIZE < nqbs_pkg::RESULT_CAP) ? MAX_SIZE : nqbs_pkg::RESULT_CAP;
    // Row and column index width, and the width of a counter that can also hold LIMIT.
    localparam int CIW   = $clog2(LIMIT);
    localparam int RW    = $clog2(LIMIT + 1);
    // Each diagonal family has 2 * LIMIT - 1 members.
    localparam int DL    = 2 * LIMIT - 1;
    localparam int DIW   = $clog2(DL);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRY,
        S_BACK,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [RW-1:0]        n_reg, n_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [RW-1:0]        col_reg, col_next;
    logic [CIW-1:0]       out_row_reg, out_row_next;
    logic [LIMIT-1:0]     colmask_reg, colmask_next;
    logic [DL-1:0]        dnmask_reg, dnmask_next;
    logic [DL-1:0]        upmask_reg, upmask_next;
    logic                 strobe_reg, strobe_next;
    logic [CIW-1:0]       row_index_reg, row_index_next;
    logic                 queen_valid_reg, queen_valid_next;
    logic                 found_reg, found_next;
    logic                 last_reg, last_next;

    // Placed-column memory: one entry per row, synchronous read with registered data.
    logic [CIW-1:0]       mem [LIMIT];
    logic                 mem_we;
    logic [CIW-1:0]       mem_waddr;
    logic [CIW-1:0]       mem_wdata;
    logic [CIW-1:0]       mem_raddr;
    logic [CIW-1:0]       rdata_reg;

    // Square under test. While backtracking it is the queen read back from memory,
    // so the same index logic serves both placing and lifting a queen.
    logic [RW-1:0]        chk_col;
    logic [CIW-1:0]       row_idx;
    logic [CIW-1:0]       col_idx;
    logic [DIW:0]         dn_sum;
    logic [DIW-1:0]       dn_idx;
    logic [DIW-1:0]       up_idx;
    logic [LIMIT-1:0]     col_oh;
    logic [DL-1:0]        dn_oh;
    logic [DL-1:0]        up_oh;
    logic                 col_in_range;
    logic                 square_free;

    always_comb
    begin
        chk_col      = (state_reg == S_BACK) ? RW'(rdata_reg) : col_reg;
        row_idx      = row_reg[CIW-1:0];
        col_idx      = chk_col[CIW-1:0];
        // The down diagonal is row - col + n - 1, which stays non-negative.
        dn_sum       = (DIW+1)'(row_reg) + (DIW+1)'(n_reg) - (DIW+1)'(1) - (DIW+1)'(chk_col);
        dn_idx       = dn_sum[DIW-1:0];
        up_idx       = DIW'(row_reg) + DIW'(chk_col);
        col_oh       = LIMIT'(1) << col_idx;
        dn_oh        = DL'(1) << dn_idx;
        up_oh        = DL'(1) << up_idx;
        col_in_range = (col_reg < n_reg);
        square_free  = !colmask_reg[col_idx] && !dnmask_reg[dn_idx] && !upmask_reg[up_idx];
    end

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        out_row_next     = out_row_reg;
        colmask_next     = colmask_reg;
        dnmask_next      = dnmask_reg;
        upmask_next      = upmask_reg;
        strobe_next      = 1'b0;
        row_index_next   = row_index_reg;
        queen_valid_next = queen_valid_reg;
        found_next       = found_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        mem_waddr        = row_idx;
        mem_wdata        = col_idx;
        mem_raddr        = out_row_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (board_size == 5'd0)
                    begin
                        // An empty board is trivially solved and has no queens.
                        strobe_next      = 1'b1;
                        row_index_next   = '0;
                        queen_valid_next = 1'b0;
                        found_next       = 1'b1;
                        last_next        = 1'b1;
                    end
                    else if (board_size > 5'(LIMIT))
                    begin
                        // Boards beyond the limit are reported as unsolvable.
                        strobe_next      = 1'b1;
                        row_index_next   = '0;
                        queen_valid_next = 1'b0;
                        found_next       = 1'b0;
                        last_next        = 1'b1;
                    end
                    else
                    begin
                        n_next       = RW'(board_size);
                        row_next     = '0;
                        col_next     = '0;
                        colmask_next = '0;
                        dnmask_next  = '0;
                        upmask_next  = '0;
                        state_next   = S_TRY;
                    end
                end
            end

            S_TRY:
            begin
                if (col_in_range)
                begin
                    if (square_free)
                    begin
                        // Place the queen and move down one row.
                        mem_we       = 1'b1;
                        colmask_next = colmask_reg ^ col_oh;
                        dnmask_next  = dnmask_reg ^ dn_oh;
                        upmask_next  = upmask_reg ^ up_oh;
                        row_next     = row_reg + RW'(1);
                        col_next     = '0;
                        if (row_reg + RW'(1) == n_reg)
                        begin
                            out_row_next = '0;
                            state_next   = S_OUT;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + RW'(1);
                    end
                end
                else if (row_reg == '0)
                begin
                    // Every column of the top row failed: no solution.
                    strobe_next      = 1'b1;
                    row_index_next   = '0;
                    queen_valid_next = 1'b0;
                    found_next       = 1'b0;
                    last_next        = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    // Dead end. Fetch the previous row's queen; it was written
                    // before this read is issued, so the read sees it without forwarding.
                    row_next   = row_reg - RW'(1);
                    mem_raddr  = CIW'(row_reg - RW'(1));
                    state_next = S_BACK;
                end
            end

            S_BACK:
            begin
                // Lift the queen read back from memory and resume at its next column.
                colmask_next = colmask_reg ^ col_oh;
                dnmask_next  = dnmask_reg ^ dn_oh;
                upmask_next  = upmask_reg ^ up_oh;
                col_next     = RW'(rdata_reg) + RW'(1);
                state_next   = S_TRY;
            end

            S_OUT:
            begin
                // One row read per cycle; the read data lines up with the strobe.
                mem_raddr        = out_row_reg;
                strobe_next      = 1'b1;
                row_index_next   = out_row_reg;
                queen_valid_next = 1'b1;
                found_next       = 1'b1;
                last_next        = (RW'(out_row_reg) == n_reg - RW'(1));
                out_row_next     = out_row_reg + CIW'(1);
                if (RW'(out_row_reg) == n_reg - RW'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            n_reg           <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            out_row_reg     <= '0;
            colmask_reg     <= '0;
            dnmask_reg      <= '0;
            upmask_reg      <= '0;
            strobe_reg      <= 1'b0;
            row_index_reg   <= '0;
            queen_valid_reg <= 1'b0;
            found_reg       <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            n_reg           <= n_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            out_row_reg     <= out_row_next;
            colmask_reg     <= colmask_next;
            dnmask_reg      <= dnmask_next;
            upmask_reg      <= upmask_next;
            strobe_reg      <= strobe_next;
            row_index_reg   <= row_index_next;
            queen_valid_reg <= queen_valid_next;
            found_reg       <= found_next;
            last_reg        <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign row_index    = nqbs_pkg::COORD_W'(row_index_reg);
    assign queen_column = queen_valid_reg ? nqbs_pkg::COORD_W'(rdata_reg)
                                          : '0;
    assign queen_valid  = queen_valid_reg;
    assign found        = found_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### sv/nqbs_checker.sv
// Port-level checker for the N-queens solver core, attached with a bind.
// Depends on nqbs_pkg for port widths and on n_queens_backtrack_solver_core.
`default_nettype none

module nqbs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          strobe,
    input wire logic [nqbs_pkg::COORD_W-1:0]  row_index,
    input wire logic                          queen_valid,
    input wire logic                          found,
    input wire logic                          last
);

    // A result item without a queen is always the only item of its request.
    a_noqueen_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !queen_valid |-> last)
        else $error("result item without a queen is not marked last");

    // Queens are only reported for a solved board.
    a_queen_means_found: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && queen_valid |-> found)
        else $error("queen reported while found is clear");

    // An accepted item either starts a search or answers on the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || strobe)
        else $error("accepted item neither started a search nor answered");

    // Solution rows come out back to back in ascending order.
    a_rows_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && queen_valid && !last |=>
            strobe && queen_valid &&
            (row_index == nqbs_pkg::COORD_W'($past(row_index) + 1'b1)))
        else $error("solution rows are not consecutive");

    // The core stays busy until its final result item is issued.
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("core went idle before the final result item");

endmodule

bind n_queens_backtrack_solver_core nqbs_checker u_nqbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .row_index   (row_index),
    .queen_valid (queen_valid),
    .found       (found),
    .last        (last)
);

`default_nettype wire
